// ----- src/cfpp_pkg.sv -----
// Shared types, constants and CRC function for the framed packet parser.
`timescale 1ns / 1ps
`default_nettype none

package cfpp_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int MAX_FRAME_DEF   = 42;

    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_CNT_W  = 6;
    localparam int OUT_IDX_W  = 5;

    localparam int SYNC_LEN       = 2;
    localparam int HDR_LEN        = 6;
    localparam int HDR_END        = 8;
    localparam int FRAME_OVERHEAD = 10;
    localparam int HDR_W          = $clog2(HDR_LEN);

    localparam int HDR_VERSION = 0;
    localparam int HDR_ADDRESS = 1;
    localparam int HDR_SEQ     = 2;
    localparam int HDR_CMD     = 3;
    localparam int HDR_FLAGS   = 4;
    localparam int HDR_LENGTH  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_VERSION = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd3;

    localparam logic [BYTE_W-1:0]  SYNC_FIRST_RST    = 8'hAA;
    localparam logic [BYTE_W-1:0]  SYNC_SECOND_RST   = 8'h55;
    localparam logic [BYTE_W-1:0]  PROTO_VERSION_RST = 8'h01;
    localparam logic [LIMIT_W-1:0] PAYLOAD_LIMIT_RST = 6'd32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_FETCH,
        ST_LOAD
    } ctl_state_t;

    typedef struct packed {
        logic take;
        logic clear_k;
        logic inc_k;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic frame_ok;
        logic last_k;
        logic out_free;
    } dp_status_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ----- src/cfpp_ctrl.sv -----
// Controller state machine: byte reception and result emission sequencing.
`timescale 1ns / 1ps
`default_nettype none

module cfpp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rx_valid,
    output logic                       rx_ready,
    input  wire cfpp_pkg::dp_status_t  status,
    output cfpp_pkg::ctl_cmd_t         cmd
);
    import cfpp_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RECV;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV:
            begin
                if (rx_valid && status.frame_ok)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (status.out_free)
                    state_next = status.last_k ? ST_RECV : ST_FETCH;
            end
            default:
                state_next = ST_RECV;
        endcase
    end

    always_comb
    begin
        rx_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_RECV:
            begin
                rx_ready    = 1'b1;
                cmd.take    = rx_valid;
                cmd.clear_k = rx_valid && status.frame_ok;
            end
            ST_FETCH:
                cmd = '0;
            ST_LOAD:
            begin
                cmd.load_out = status.out_free;
                cmd.inc_k    = status.out_free && !status.last_k;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/cfpp_datapath.sv -----
// Datapath: config registers, frame counter, header, CRC, payload memory, result register.
`timescale 1ns / 1ps
`default_nettype none

module cfpp_datapath #(
    parameter int MAX_PAYLOAD = cfpp_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_FRAME   = cfpp_pkg::MAX_FRAME_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [cfpp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [cfpp_pkg::BYTE_W-1:0]           cfg_data,
    input  wire logic [cfpp_pkg::BYTE_W-1:0]           rx_byte,
    input  wire cfpp_pkg::ctl_cmd_t                    cmd,
    output cfpp_pkg::dp_status_t                       status,
    input  wire logic                                  res_ready,
    output logic                                       res_valid,
    output logic [cfpp_pkg::BYTE_W-1:0]                node_address,
    output logic [cfpp_pkg::BYTE_W-1:0]                sequence_no,
    output logic [cfpp_pkg::BYTE_W-1:0]                command_code,
    output logic [cfpp_pkg::BYTE_W-1:0]                flag_bits,
    output logic [cfpp_pkg::OUT_CNT_W-1:0]             payload_count,
    output logic [cfpp_pkg::OUT_IDX_W-1:0]             payload_index,
    output logic [cfpp_pkg::BYTE_W-1:0]                payload_byte,
    output logic                                       last_of_frame
);
    import cfpp_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int CMP_W = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int IW    = (AW > OUT_IDX_W) ? AW : OUT_IDX_W;

    logic [BYTE_W-1:0]  sync_first_reg;
    logic [BYTE_W-1:0]  sync_second_reg;
    logic [BYTE_W-1:0]  proto_version_reg;
    logic [LIMIT_W-1:0] payload_limit_reg;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BYTE_W-1:0]  hdr_reg [HDR_LEN];
    logic [BYTE_W-1:0]  hdr_next [HDR_LEN];
    logic [15:0]        crc_reg, crc_next;
    logic [BYTE_W-1:0]  crc_low_reg, crc_low_next;
    logic [AW-1:0]      k_reg, k_next;

    logic [BYTE_W-1:0]  mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;

    logic [CMP_W-1:0]   p_w, cnt1_w, pay_off, plen_cur, plen_new, lim_w, n_w;
    logic [HDR_W-1:0]   hidx;
    logic               done;
    logic [IW-1:0]      k_wide;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg    <= SYNC_FIRST_RST;
            sync_second_reg   <= SYNC_SECOND_RST;
            proto_version_reg <= PROTO_VERSION_RST;
            payload_limit_reg <= PAYLOAD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:    sync_first_reg    <= cfg_data;
                CFG_SYNC_SECOND:   sync_second_reg   <= cfg_data;
                CFG_PROTO_VERSION: proto_version_reg <= cfg_data;
                CFG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign p_w      = CMP_W'(cnt_reg);
    assign cnt1_w   = p_w + CMP_W'(1);
    assign pay_off  = p_w - CMP_W'(HDR_END);
    assign hidx     = HDR_W'(p_w - CMP_W'(SYNC_LEN));
    assign plen_cur = CMP_W'(hdr_reg[HDR_LENGTH]);
    assign plen_new = (p_w == CMP_W'(HDR_END - 1)) ? CMP_W'(rx_byte) : plen_cur;
    assign lim_w    = (CMP_W'(payload_limit_reg) > CMP_W'(MAX_PAYLOAD)) ?
                      CMP_W'(MAX_PAYLOAD) : CMP_W'(payload_limit_reg);
    assign mem_waddr = pay_off[AW-1:0];

    // per-byte frame tracking
    always_comb
    begin
        cnt_next     = cnt_reg;
        hdr_next     = hdr_reg;
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        mem_we       = 1'b0;
        done         = 1'b0;
        if (cnt_reg == CNT_W'(0))
        begin
            if (rx_byte == sync_first_reg)
                cnt_next = CNT_W'(1);
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            if (rx_byte == sync_second_reg)
                cnt_next = CNT_W'(2);
            else if (rx_byte == sync_first_reg)
                cnt_next = CNT_W'(1);
            else
                cnt_next = CNT_W'(0);
        end
        else if (p_w >= CMP_W'(MAX_FRAME))
        begin
            cnt_next = CNT_W'(0);
        end
        else
        begin
            if (p_w < CMP_W'(HDR_END))
            begin
                hdr_next[hidx] = rx_byte;
                crc_next = crc16_update((p_w == CMP_W'(SYNC_LEN)) ? CRC_INIT : crc_reg,
                                        rx_byte);
            end
            else if (p_w < CMP_W'(HDR_END) + plen_cur)
            begin
                mem_we   = (pay_off < CMP_W'(MAX_PAYLOAD));
                crc_next = crc16_update(crc_reg, rx_byte);
            end
            else if (p_w == CMP_W'(HDR_END) + plen_cur)
            begin
                crc_low_next = rx_byte;
            end
            cnt_next = CNT_W'(cnt1_w);
            if (cnt1_w >= CMP_W'(HDR_END))
            begin
                if (plen_new > lim_w)
                begin
                    cnt_next = CNT_W'(0);
                end
                else if (cnt1_w == CMP_W'(FRAME_OVERHEAD) + plen_new)
                begin
                    cnt_next = CNT_W'(0);
                    done     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            crc_reg     <= CRC_INIT;
            crc_low_reg <= '0;
            for (int i = 0; i < HDR_LEN; i++)
                hdr_reg[i] <= '0;
        end
        else if (cmd.take)
        begin
            cnt_reg     <= cnt_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
            hdr_reg     <= hdr_next;
        end
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (cmd.take && mem_we)
            mem[mem_waddr] <= rx_byte;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[k_reg];
    end

    // emission index
    always_comb
    begin
        k_next = k_reg;
        if (cmd.clear_k)
            k_next = '0;
        else if (cmd.inc_k)
            k_next = k_reg + AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= '0;
        else
            k_reg <= k_next;
    end

    assign n_w    = (plen_cur == '0) ? CMP_W'(1) : plen_cur;
    assign k_wide = IW'(k_reg);

    assign status.frame_ok = done && (hdr_reg[HDR_VERSION] == proto_version_reg) &&
                             ({rx_byte, crc_low_reg} == crc_reg);
    assign status.last_k   = (CMP_W'(k_reg) + CMP_W'(1)) == n_w;
    assign status.out_free = !res_valid || res_ready;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid <= 1'b0;
        else if (cmd.load_out)
            res_valid <= 1'b1;
        else if (res_ready)
            res_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            node_address  <= hdr_reg[HDR_ADDRESS];
            sequence_no   <= hdr_reg[HDR_SEQ];
            command_code  <= hdr_reg[HDR_CMD];
            flag_bits     <= hdr_reg[HDR_FLAGS];
            payload_count <= hdr_reg[HDR_LENGTH][OUT_CNT_W-1:0];
            payload_index <= k_wide[OUT_IDX_W-1:0];
            payload_byte  <= (plen_cur == '0) ? '0 : rd_data_reg;
            last_of_frame <= status.last_k;
        end
    end

endmodule

`default_nettype wire

// ----- src/crc16_framed_packet_parser.sv -----
// Top level of the CRC-16 framed packet parser.
// Reception: one byte per cycle; rx_ready is low while a good frame is emitted.
// Emission: after the closing CRC byte, each result passes a fetch state (payload memory
// read) and a load state; a load waits while res_valid is high and res_ready is low.
// A good frame of n payload bytes holds off input until its max(n,1) results are loaded.
// Reset restores register defaults and CRC_INIT, clears counters; payload memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module crc16_framed_packet_parser #(
    parameter int MAX_PAYLOAD = cfpp_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_FRAME   = cfpp_pkg::MAX_FRAME_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [cfpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cfpp_pkg::BYTE_W-1:0]       cfg_data,
    input  wire logic                              rx_valid,
    output logic                                   rx_ready,
    input  wire logic [cfpp_pkg::BYTE_W-1:0]       rx_byte,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output logic [cfpp_pkg::BYTE_W-1:0]            node_address,
    output logic [cfpp_pkg::BYTE_W-1:0]            sequence_no,
    output logic [cfpp_pkg::BYTE_W-1:0]            command_code,
    output logic [cfpp_pkg::BYTE_W-1:0]            flag_bits,
    output logic [cfpp_pkg::OUT_CNT_W-1:0]         payload_count,
    output logic [cfpp_pkg::OUT_IDX_W-1:0]         payload_index,
    output logic [cfpp_pkg::BYTE_W-1:0]            payload_byte,
    output logic                                   last_of_frame
);
    import cfpp_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    cfpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cfpp_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_FRAME   (MAX_FRAME)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_byte       (rx_byte),
        .cmd           (cmd),
        .status        (status),
        .res_ready     (res_ready),
        .res_valid     (res_valid),
        .node_address  (node_address),
        .sequence_no   (sequence_no),
        .command_code  (command_code),
        .flag_bits     (flag_bits),
        .payload_count (payload_count),
        .payload_index (payload_index),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame)
    );

endmodule

`default_nettype wire

// ----- sim/cfpp_checker.sv -----
// Scoreboard for the framed packet parser: predicts results from accepted bytes and compares.
`timescale 1ns / 1ps

module cfpp_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cfpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfpp_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                              rx_valid,
    input  logic                              rx_ready,
    input  logic [cfpp_pkg::BYTE_W-1:0]       rx_byte,
    input  logic                              res_valid,
    input  logic                              res_ready,
    input  logic [cfpp_pkg::BYTE_W-1:0]       node_address,
    input  logic [cfpp_pkg::BYTE_W-1:0]       sequence_no,
    input  logic [cfpp_pkg::BYTE_W-1:0]       command_code,
    input  logic [cfpp_pkg::BYTE_W-1:0]       flag_bits,
    input  logic [cfpp_pkg::OUT_CNT_W-1:0]    payload_count,
    input  logic [cfpp_pkg::OUT_IDX_W-1:0]    payload_index,
    input  logic [cfpp_pkg::BYTE_W-1:0]       payload_byte,
    input  logic                              last_of_frame,
    output int                                fail_count,
    output int                                results_pending
);

    import cfpp_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]    node_address;
        logic [BYTE_W-1:0]    sequence_no;
        logic [BYTE_W-1:0]    command_code;
        logic [BYTE_W-1:0]    flag_bits;
        logic [OUT_CNT_W-1:0] payload_count;
        logic [OUT_IDX_W-1:0] payload_index;
        logic [BYTE_W-1:0]    payload_byte;
        logic                 last_of_frame;
    } frame_result_t;

    frame_result_t expected_results[$];
    frame_result_t head_result;

    logic [BYTE_W-1:0]  magic_first;
    logic [BYTE_W-1:0]  magic_second;
    logic [BYTE_W-1:0]  accepted_version;
    logic [LIMIT_W-1:0] length_limit;

    int                 frame_pos;
    logic [BYTE_W-1:0]  hdr_bytes [HDR_LEN];
    logic [15:0]        crc_acc;
    logic [BYTE_W-1:0]  crc_lo_rx;
    logic [BYTE_W-1:0]  payload_mem [MAX_PAYLOAD_DEF];

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [BYTE_W-1:0] data);
        logic [15:0] r;
        r = acc ^ {8'h00, data};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        int p;
        int plen;
        int lim;
        int n;
        frame_result_t r;
        if (frame_pos == 0)
        begin
            if (b == magic_first)
                frame_pos = 1;
            return;
        end
        if (frame_pos == 1)
        begin
            if (b != magic_second)
                frame_pos = (b == magic_first) ? 1 : 0;
            else
                frame_pos = 2;
            return;
        end
        if (frame_pos >= MAX_FRAME_DEF)
        begin
            frame_pos = 0;
            return;
        end

        p = frame_pos;
        frame_pos = p + 1;
        if (p < HDR_END)
        begin
            hdr_bytes[p - SYNC_LEN] = b;
            crc_acc = modbus_crc_step((p == SYNC_LEN) ? CRC_INIT : crc_acc, b);
        end
        else
        begin
            plen = int'(hdr_bytes[HDR_LENGTH]);
            if (p < HDR_END + plen)
            begin
                if (p - HDR_END < MAX_PAYLOAD_DEF)
                    payload_mem[p - HDR_END] = b;
                crc_acc = modbus_crc_step(crc_acc, b);
            end
            else if (p == HDR_END + plen)
                crc_lo_rx = b;
        end

        if (frame_pos < HDR_END)
            return;
        plen = int'(hdr_bytes[HDR_LENGTH]);
        lim = (int'(length_limit) > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(length_limit);
        if (plen > lim)
        begin
            frame_pos = 0;
            return;
        end
        if (frame_pos != FRAME_OVERHEAD + plen)
            return;

        frame_pos = 0;
        if (hdr_bytes[HDR_VERSION] != accepted_version)
            return;
        if ({b, crc_lo_rx} != crc_acc)
            return;

        n = (plen == 0) ? 1 : plen;
        for (int k = 0; k < n; k++)
        begin
            r.node_address  = hdr_bytes[HDR_ADDRESS];
            r.sequence_no   = hdr_bytes[HDR_SEQ];
            r.command_code  = hdr_bytes[HDR_CMD];
            r.flag_bits     = hdr_bytes[HDR_FLAGS];
            r.payload_count = OUT_CNT_W'(plen);
            r.payload_index = OUT_IDX_W'(k);
            r.payload_byte  = (plen != 0) ? payload_mem[k] : 8'h00;
            r.last_of_frame = (k == n - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_first      = SYNC_FIRST_RST;
            magic_second     = SYNC_SECOND_RST;
            accepted_version = PROTO_VERSION_RST;
            length_limit     = PAYLOAD_LIMIT_RST;
            frame_pos        = 0;
            crc_acc          = CRC_INIT;
            crc_lo_rx        = '0;
            foreach (hdr_bytes[i])
                hdr_bytes[i] = '0;
            expected_results.delete();
            fail_count       = 0;
            results_pending  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:    magic_first      = cfg_data;
                    CFG_SYNC_SECOND:   magic_second     = cfg_data;
                    CFG_PROTO_VERSION: accepted_version = cfg_data;
                    CFG_PAYLOAD_LIMIT: length_limit     = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $write("%0t: unexpected result, expected none, got addr %0d seq %0d",
                           $time, node_address, sequence_no);
                    $display(" cmd %0d flags %0d count %0d index %0d byte %0d last %0d",
                             command_code, flag_bits, payload_count, payload_index,
                             payload_byte, last_of_frame);
                end
                else
                begin
                    head_result = expected_results.pop_front();
                    check_field("node_address", head_result.node_address, node_address);
                    check_field("sequence_no", head_result.sequence_no, sequence_no);
                    check_field("command_code", head_result.command_code, command_code);
                    check_field("flag_bits", head_result.flag_bits, flag_bits);
                    check_field("payload_count", head_result.payload_count, payload_count);
                    check_field("payload_index", head_result.payload_index, payload_index);
                    check_field("payload_byte", head_result.payload_byte, payload_byte);
                    check_field("last_of_frame", head_result.last_of_frame, last_of_frame);
                end
            end

            if (rx_valid && rx_ready)
                parse_byte(rx_byte);

            results_pending = expected_results.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the framed packet parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    import cfpp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam int TAIL_CYCLES  = 20;
    localparam int LONG_HOLD    = 300;
    localparam int SEND_ALL     = 1 << 30;

    typedef enum int {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PATTERN
    } sink_mode_t;

    typedef enum int {
        FK_GOOD,
        FK_BAD_CRC,
        FK_BAD_VERSION,
        FK_OVERSIZE,
        FK_NOISE
    } frame_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 rx_valid = 1'b0;
    logic                 rx_ready;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic [BYTE_W-1:0]    node_address;
    logic [BYTE_W-1:0]    sequence_no;
    logic [BYTE_W-1:0]    command_code;
    logic [BYTE_W-1:0]    flag_bits;
    logic [OUT_CNT_W-1:0] payload_count;
    logic [OUT_IDX_W-1:0] payload_index;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 last_of_frame;
    int                   fail_count;
    int                   results_pending;

    logic [BYTE_W-1:0]  sync_a = SYNC_FIRST_RST;
    logic [BYTE_W-1:0]  sync_b = SYNC_SECOND_RST;
    logic [BYTE_W-1:0]  cur_version = PROTO_VERSION_RST;
    logic [LIMIT_W-1:0] cur_limit = PAYLOAD_LIMIT_RST;
    logic [BYTE_W-1:0]  tx_q[$];
    int                 sent_bytes = 0;
    int                 burst_left = 0;
    int                 hold_requests = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 mode_left = 0;
    sink_mode_t         sink_mode = RDY_ALWAYS;
    int                 cycle_count = 0;

    crc16_framed_packet_parser dut (.*);

    cfpp_checker chk (.*);

    always #1 clk = ~clk;

    // result sink: random stall modes plus a long hold-off on each hold request
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (mode_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                RDY_ALWAYS: res_ready <= 1'b1;
                RDY_MOSTLY: res_ready <= ($urandom_range(0, 3) != 0);
                RDY_RARELY: res_ready <= ($urandom_range(0, 3) == 0);
                default:    res_ready <= mode_left[2];
            endcase
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                rx_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_queued(input int count);
        for (int i = 0; i < count && tx_q.size() > 0; i++)
            send_byte(tx_q.pop_front());
    endtask

    task automatic queue_frame(input logic [BYTE_W-1:0] ver, input logic [BYTE_W-1:0] addr,
                               input logic [BYTE_W-1:0] seq, input logic [BYTE_W-1:0] cmd,
                               input logic [BYTE_W-1:0] flags, input int len,
                               input bit corrupt);
        logic [15:0]       crc;
        logic [BYTE_W-1:0] hdr [HDR_LEN];
        logic [BYTE_W-1:0] b;
        crc = CRC_INIT;
        hdr = '{ver, addr, seq, cmd, flags, BYTE_W'(len)};
        tx_q.push_back(sync_a);
        tx_q.push_back(sync_b);
        foreach (hdr[i])
        begin
            tx_q.push_back(hdr[i]);
            crc = crc16_update(crc, hdr[i]);
        end
        for (int i = 0; i < len; i++)
        begin
            b = rand_byte();
            tx_q.push_back(b);
            crc = crc16_update(crc, b);
        end
        if (corrupt)
            crc = crc ^ 16'($urandom_range(1, 65535));
        tx_q.push_back(crc[7:0]);
        tx_q.push_back(crc[15:8]);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                              input logic [BYTE_W-1:0] ver, input logic [LIMIT_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= s1;
        @(negedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data  <= s2;
        @(negedge clk);
        cfg_index <= CFG_PROTO_VERSION;
        cfg_data  <= ver;
        @(negedge clk);
        cfg_index <= CFG_PAYLOAD_LIMIT;
        cfg_data  <= {{(BYTE_W-LIMIT_W){1'b0}}, lim};
        @(negedge clk);
        cfg_we    <= 1'b0;
        sync_a      = s1;
        sync_b      = s2;
        cur_version = ver;
        cur_limit   = lim;
    endtask

    task automatic drain();
        rx_valid <= 1'b0;
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input int n_bytes);
        int          start;
        int          eff;
        int          len;
        int          pick;
        frame_kind_t kind;
        start = sent_bytes;
        eff = (int'(cur_limit) > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(cur_limit);
        while (sent_bytes - start < n_bytes)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 10)
                kind = FK_GOOD;
            else if (pick == 10)
                kind = FK_BAD_CRC;
            else if (pick == 11)
                kind = FK_BAD_VERSION;
            else if (pick < 14)
                kind = FK_OVERSIZE;
            else
                kind = FK_NOISE;

            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(0, eff);
            else
                len = $urandom_range(0, (eff < 4) ? eff : 4);

            case (kind)
                FK_GOOD:
                    queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(),
                                rand_byte(), len, 1'b0);
                FK_BAD_CRC:
                    queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(),
                                rand_byte(), len, 1'b1);
                FK_BAD_VERSION:
                    queue_frame(cur_version ^ BYTE_W'($urandom_range(1, 255)), rand_byte(),
                                rand_byte(), rand_byte(), rand_byte(), len, 1'b0);
                FK_OVERSIZE:
                    queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(),
                                rand_byte(), eff + $urandom_range(1, 3), 1'b0);
                default:
                    repeat ($urandom_range(1, 4))
                        tx_q.push_back(($urandom_range(0, 2) == 0) ? sync_a : rand_byte());
            endcase
            send_queued(SEND_ALL);
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames at reset settings, under a long result hold-off
        hold_requests++;
        queue_frame(cur_version, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b0);
        queue_frame(cur_version, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1'b0);
        queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                    MAX_PAYLOAD_DEF, 1'b0);
        queue_frame(cur_version + 8'd1, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                    2, 1'b0);
        queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 3, 1'b1);
        tx_q.push_back(sync_a);
        queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1, 1'b0);
        tx_q.push_back(sync_a);
        tx_q.push_back(8'h12);
        queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 0, 1'b0);
        queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                    MAX_PAYLOAD_DEF + 1, 1'b0);
        send_queued(SEND_ALL);

        // limit lowered while a frame is half received
        queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 5, 1'b0);
        send_queued(10);
        drain();
        set_config(sync_a, sync_b, cur_version, 6'd2);
        send_queued(SEND_ALL);
        queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 2, 1'b0);
        queue_frame(cur_version, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 3, 1'b0);
        send_queued(SEND_ALL);
        drain();

        set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, PROTO_VERSION_RST, PAYLOAD_LIMIT_RST);
        random_phase(PHASE_BYTES);
        drain();

        set_config(8'h00, 8'hFF, 8'hFF, 6'd0);
        random_phase(PHASE_BYTES);
        drain();

        set_config(8'hFF, 8'h00, 8'h00, 6'd63);
        random_phase(PHASE_BYTES);
        drain();

        set_config(rand_byte(), rand_byte(), rand_byte(), LIMIT_W'($urandom_range(1, 32)));
        random_phase(PHASE_BYTES);
        drain();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
